// ----- sv/lpd_pkg.sv -----
// Shared types, constants and codes for the 4-neighbor local peak detector.
package lpd_pkg;

  // Field widths fixed by the beat formats.
  localparam int PIXEL_BITS   = 16;
  localparam int ROW_BITS     = 10;
  localparam int COL_BITS     = 10;
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;

  // Default frame store limits.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Frame size after reset.
  localparam logic [CFG_BITS-1:0] RESET_FRAME_WIDTH  = 11'd4;
  localparam logic [CFG_BITS-1:0] RESET_FRAME_HEIGHT = 11'd3;

  // Input beat kinds.
  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input beat.
  typedef struct packed {
    action_t                       action;
    logic signed [PIXEL_BITS-1:0]  pixel_value;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [ROW_BITS-1:0]           peak_row;
    logic [COL_BITS-1:0]           peak_col;
    logic signed [PIXEL_BITS-1:0]  center_value;
    logic                          is_peak;
    logic                          frame_last;
  } out_beat_t;

  // Judgment controls handed from the front end to the compare stage.
  typedef struct packed {
    logic                          has_up;
    logic                          has_down;
    logic                          has_left;
    logic                          has_right;
    logic                          frame_last;
    logic                          wr_above;
    logic [ROW_BITS-1:0]           row;
    logic [COL_BITS-1:0]           col;
    logic signed [PIXEL_BITS-1:0]  below;
  } judge_ctl_t;

endpackage

// ----- sv/lpd_front.sv -----
// Front end: frame size registers, raster counters, drain sequencing and line store addressing.
module lpd_front #(
  parameter int MAX_WIDTH  = lpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lpd_pkg::MAX_HEIGHT_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lpd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lpd_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  lpd_pkg::in_beat_t                    in_data,
  input  logic                                 in_accept,
  output logic                                 rd_en,
  output logic [AW-1:0]                        rd_addr,
  output logic [AW-1:0]                        rd_addr_nx,
  output logic                                 mid_we,
  output logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_wdata,
  output lpd_pkg::judge_ctl_t                  ctl
);

  logic [lpd_pkg::CFG_BITS-1:0] width_cfg_r;
  logic [lpd_pkg::CFG_BITS-1:0] height_cfg_r;
  logic [AW-1:0]                col_r;
  logic [RW-1:0]                row_r;
  logic [WW-1:0]                drain_r;
  logic                         draining_r;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          col_wrap;
  logic [AW-1:0] c;
  logic [RW:0]   row0;
  logic [RW-1:0] r;
  logic [WW-1:0] c_p1;
  logic          last_col;
  logic          last_row;
  logic [WW-1:0] d_p1;
  logic          d_ok;
  logic          is_pix;
  logic          is_drn;

  // Sizes of zero act as one; sizes above the store limits act as the limit.
  always_comb begin
    if (width_cfg_r == '0) begin
      w = WW'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h = HW'(1);
    end else if (int'(height_cfg_r) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_cfg_r);
    end
  end

  // Current raster position, wrapping when a counter sits at or past the size.
  always_comb begin
    col_wrap = WW'(col_r) >= w;
    c        = col_wrap ? '0 : col_r;
    row0     = col_wrap ? ({1'b0, row_r} + (RW+1)'(1)) : {1'b0, row_r};
    r        = (int'(row0) >= int'(h)) ? '0 : row0[RW-1:0];
    c_p1     = WW'(c) + WW'(1);
    last_col = c_p1 >= w;
    last_row = (int'(r) + 1) >= int'(h);
    d_ok     = drain_r < w;
    d_p1     = drain_r + WW'(1);
  end

  // Beat classification: pixels are dropped while draining, drains outside it.
  assign is_pix = (in_data.action == lpd_pkg::ACT_PIXEL) && !draining_r;
  assign is_drn = (in_data.action == lpd_pkg::ACT_DRAIN) && draining_r;

  // Line store strobes and read addresses for the pixel above or the drained pixel.
  always_comb begin
    rd_en     = in_accept && ((is_pix && (r != '0)) || (is_drn && d_ok));
    mid_we    = in_accept && is_pix;
    mid_wdata = in_data.pixel_value;
    if (is_drn) begin
      rd_addr    = AW'(drain_r);
      rd_addr_nx = (d_p1 >= w) ? '0 : AW'(d_p1);
    end else begin
      rd_addr    = c;
      rd_addr_nx = last_col ? '0 : AW'(c_p1);
    end
  end

  // Neighbor presence and reported position for the compare stage.
  always_comb begin
    ctl.below = in_data.pixel_value;
    if (is_drn) begin
      ctl.has_up     = h > HW'(1);
      ctl.has_down   = 1'b0;
      ctl.has_left   = drain_r != '0;
      ctl.has_right  = d_p1 < w;
      ctl.frame_last = d_p1 == w;
      ctl.wr_above   = 1'b0;
      ctl.row        = lpd_pkg::ROW_BITS'(h - HW'(1));
      ctl.col        = lpd_pkg::COL_BITS'(drain_r);
    end else begin
      ctl.has_up     = r > RW'(1);
      ctl.has_down   = 1'b1;
      ctl.has_left   = c != '0;
      ctl.has_right  = !last_col;
      ctl.frame_last = 1'b0;
      ctl.wr_above   = 1'b1;
      ctl.row        = lpd_pkg::ROW_BITS'(r - RW'(1));
      ctl.col        = lpd_pkg::COL_BITS'(c);
    end
  end

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= lpd_pkg::RESET_FRAME_WIDTH;
      height_cfg_r <= lpd_pkg::RESET_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpd_pkg::REG_FRAME_WIDTH:  width_cfg_r  <= cfg_wdata;
        lpd_pkg::REG_FRAME_HEIGHT: height_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Raster and drain counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      draining_r <= 1'b0;
    end else if (in_accept) begin
      if (is_pix) begin
        if (last_col) begin
          col_r <= '0;
          if (last_row) begin
            row_r      <= '0;
            draining_r <= 1'b1;
            drain_r    <= '0;
          end else begin
            row_r <= RW'(int'(r) + 1);
          end
        end else begin
          col_r <= AW'(c_p1);
          row_r <= r;
        end
      end else if (is_drn) begin
        if (!d_ok) begin
          draining_r <= 1'b0;
        end else begin
          drain_r <= d_p1;
          if (d_p1 >= w) begin
            draining_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- sv/lpd_line_store.sv -----
// Two line stores holding the previous two rows, with registered reads and write forwarding.
module lpd_line_store #(
  parameter int MAX_WIDTH = lpd_pkg::MAX_WIDTH_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [AW-1:0]                         rd_addr,
  input  logic [AW-1:0]                         rd_addr_nx,
  input  logic                                  mid_we,
  input  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_wdata,
  input  logic                                  abv_we,
  input  logic [AW-1:0]                         abv_waddr,
  input  logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_wdata,
  output logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_c,
  output logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_n,
  output logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_c
);

  logic [lpd_pkg::PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [lpd_pkg::PIXEL_BITS-1:0] abv_mem [MAX_WIDTH];

  logic [lpd_pkg::PIXEL_BITS-1:0] mid_c_r;
  logic [lpd_pkg::PIXEL_BITS-1:0] mid_n_r;
  logic [lpd_pkg::PIXEL_BITS-1:0] abv_rd_r;
  logic [lpd_pkg::PIXEL_BITS-1:0] fwd_data_r;
  logic                           fwd_hit_r;

  // Middle row: the new pixel is written as the old one at that column is read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_c_r <= mid_mem[rd_addr];
      mid_n_r <= mid_mem[rd_addr_nx];
    end
    if (mid_we) begin
      mid_mem[rd_addr] <= mid_wdata;
    end
  end

  // Upper row: written from the compare stage as the judged pixel leaves it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      abv_rd_r <= abv_mem[rd_addr];
    end
    if (abv_we) begin
      abv_mem[abv_waddr] <= abv_wdata;
    end
  end

  // A read that meets a same-cycle write to the upper row takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r  <= abv_we && (abv_waddr == rd_addr);
      fwd_data_r <= abv_wdata;
    end
  end

  assign mid_c = mid_c_r;
  assign mid_n = mid_n_r;
  assign abv_c = fwd_hit_r ? fwd_data_r : abv_rd_r;

endmodule

// ----- sv/lpd_judge.sv -----
// Compare stage: judges one pixel against its neighbors and holds the result beat.
module lpd_judge #(
  parameter int MAX_WIDTH = lpd_pkg::MAX_WIDTH_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  lpd_pkg::judge_ctl_t                   ctl_in,
  input  logic [AW-1:0]                         addr_in,
  input  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_c,
  input  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_n,
  input  logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_c,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output lpd_pkg::out_beat_t                    out_data,
  output logic                                  stage_free,
  output logic                                  abv_we,
  output logic [AW-1:0]                         abv_waddr,
  output logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_wdata
);

  logic                                  s1_v_r;
  lpd_pkg::judge_ctl_t                   ctl_r;
  logic [AW-1:0]                         addr_r;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] prev_ctr_r;
  logic                                  out_v_r;
  lpd_pkg::out_beat_t                    out_data_r;

  logic adv;
  logic peak;

  // The stage moves on when the result register is empty or being emptied.
  assign adv        = s1_v_r && (!out_v_r || out_ready);
  assign stage_free = !s1_v_r || adv;

  // Strictly greater than every neighbor that exists.
  always_comb begin
    peak = !((ctl_r.has_up    && (abv_c       >= mid_c)) ||
             (ctl_r.has_down  && (ctl_r.below >= mid_c)) ||
             (ctl_r.has_left  && (prev_ctr_r  >= mid_c)) ||
             (ctl_r.has_right && (mid_n       >= mid_c)));
  end

  // The judged pixel moves into the upper row store as it leaves.
  assign abv_we    = adv && ctl_r.wr_above;
  assign abv_waddr = addr_r;
  assign abv_wdata = mid_c;

  // Stage control and the previous center, which is the next left neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (load) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r  <= ctl_in;
      addr_r <= addr_in;
    end
    if (adv) begin
      prev_ctr_r <= mid_c;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.peak_row     <= ctl_r.row;
      out_data_r.peak_col     <= ctl_r.col;
      out_data_r.center_value <= mid_c;
      out_data_r.is_peak      <= peak;
      out_data_r.frame_last   <= ctl_r.frame_last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // A beat is only loaded into a stage that is empty or moving on.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> stage_free)
    else $error("beat loaded into a stalled compare stage");

  // A loaded beat is held in the stage on the next cycle.
  a_load_held: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> s1_v_r)
    else $error("loaded beat lost from the compare stage");

  // The last drained pixel of a frame never writes the upper row store.
  a_drain_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && ctl_r.frame_last) |-> !abv_we)
    else $error("drain beat wrote the upper row store");

  // A result beat appears in the cycle after the stage moves on.
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("judged beat did not reach the result register");

endmodule

// ----- sv/local_peak_detect_4n.sv -----
// A pixel's result follows the accepted beat of the pixel below it; a last-row result follows
// each accepted drain beat. Both pass the registered line store read, compare and result stages.
// Throughput: one beat per clock unless output stalls; a judged beat takes one read and one compare.
// Reset: counters and the drain flag clear, the frame size returns to 4 by 3.
// Reset does not clear the line stores; each entry is written before a read of it is used.
module local_peak_detect_4n #(
  parameter int MAX_WIDTH  = lpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lpd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lpd_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lpd_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lpd_pkg::out_beat_t               out_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                                  in_accept;
  logic                                  rd_en;
  logic [AW-1:0]                         rd_addr;
  logic [AW-1:0]                         rd_addr_nx;
  logic                                  mid_we;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_wdata;
  lpd_pkg::judge_ctl_t                   ctl;
  logic                                  abv_we;
  logic [AW-1:0]                         abv_waddr;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_wdata;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_c;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] mid_n;
  logic signed [lpd_pkg::PIXEL_BITS-1:0] abv_c;
  logic                                  stage_free;

  // Input beats are taken whenever the compare stage can make room.
  assign in_ready  = stage_free;
  assign in_accept = in_valid && in_ready;

  lpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_data),
    .in_accept  (in_accept),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_addr_nx (rd_addr_nx),
    .mid_we     (mid_we),
    .mid_wdata  (mid_wdata),
    .ctl        (ctl)
  );

  lpd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_addr_nx (rd_addr_nx),
    .mid_we     (mid_we),
    .mid_wdata  (mid_wdata),
    .abv_we     (abv_we),
    .abv_waddr  (abv_waddr),
    .abv_wdata  (abv_wdata),
    .mid_c      (mid_c),
    .mid_n      (mid_n),
    .abv_c      (abv_c)
  );

  lpd_judge #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (rd_en),
    .ctl_in     (ctl),
    .addr_in    (rd_addr),
    .mid_c      (mid_c),
    .mid_n      (mid_n),
    .abv_c      (abv_c),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .stage_free (stage_free),
    .abv_we     (abv_we),
    .abv_waddr  (abv_waddr),
    .abv_wdata  (abv_wdata)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the 4-neighbor local peak detector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 560;
  localparam int LONG_HOLD    = 64;
  localparam int SETTLE       = 6;

  // Opening frame at the reset size of 4 by 3: extremes, ties and a few clear peaks.
  localparam logic signed [lpd_pkg::PIXEL_BITS-1:0] OPENING_FRAME [12] = '{
    16'sh8000, 16'sh7FFF, 16'sd100,  16'sd100,
    16'sd0,    -16'sd1,   16'sh7FFF, 16'sh8000,
    -16'sd5,   16'sd200,  16'sh7FFF, 16'sd1
  };

  // Mirror of the detector: frame position, line stores and the verdicts still owed.
  class peak_judge;
    logic [lpd_pkg::CFG_BITS-1:0]          width_reg;
    logic [lpd_pkg::CFG_BITS-1:0]          height_reg;
    logic signed [lpd_pkg::PIXEL_BITS-1:0] above_line [lpd_pkg::MAX_WIDTH_DEF];
    logic signed [lpd_pkg::PIXEL_BITS-1:0] middle_line [lpd_pkg::MAX_WIDTH_DEF];
    int unsigned                           col;
    int unsigned                           row;
    int unsigned                           drained;
    bit                                    draining;
    lpd_pkg::out_beat_t                    pending_verdicts [$];
    int                                    errors;

    function new();
      width_reg  = lpd_pkg::RESET_FRAME_WIDTH;
      height_reg = lpd_pkg::RESET_FRAME_HEIGHT;
      for (int i = 0; i < lpd_pkg::MAX_WIDTH_DEF; i++) begin
        above_line[i]  = '0;
        middle_line[i] = '0;
      end
      col      = 0;
      row      = 0;
      drained  = 0;
      draining = 1'b0;
      errors   = 0;
    endfunction

    // A size of zero acts as one; anything past the store depth acts as the depth.
    function int unsigned clamp_dim(logic [lpd_pkg::CFG_BITS-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
    endfunction

    function void set_size(lpd_pkg::cfg_reg_t idx, logic [lpd_pkg::CFG_BITS-1:0] v);
      case (idx)
        lpd_pkg::REG_FRAME_WIDTH:  width_reg  = v;
        lpd_pkg::REG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    // Work out the verdict, if any, that one accepted input beat releases.
    function void take_beat(lpd_pkg::in_beat_t b);
      int unsigned                           w;
      int unsigned                           h;
      int unsigned                           c;
      logic signed [lpd_pkg::PIXEL_BITS-1:0] ctr;
      bit                                    peak;
      lpd_pkg::out_beat_t                    v;
      w = clamp_dim(width_reg, lpd_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, lpd_pkg::MAX_HEIGHT_DEF);

      // A drain beat releases one last-row verdict, and only after the frame is complete.
      if (b.action == lpd_pkg::ACT_DRAIN) begin
        if (!draining) return;
        if (drained >= w) begin
          draining = 1'b0;
          return;
        end
        c    = drained;
        ctr  = middle_line[c];
        peak = 1'b1;
        if (h > 1) if (above_line[c] >= ctr) peak = 1'b0;
        if (c > 0) if (middle_line[c-1] >= ctr) peak = 1'b0;
        if (c + 1 < w) if (middle_line[c+1] >= ctr) peak = 1'b0;
        v.peak_row     = lpd_pkg::ROW_BITS'(h - 1);
        v.peak_col     = lpd_pkg::COL_BITS'(c);
        v.center_value = ctr;
        v.is_peak      = peak;
        v.frame_last   = (c + 1 == w);
        pending_verdicts.push_back(v);
        drained = c + 1;
        if (drained >= w) draining = 1'b0;
        return;
      end

      // Pixels that show up while the last row drains are dropped.
      if (draining) return;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      c = col;

      // The pixel below completes the neighborhood of the stored middle-row pixel.
      if (row > 0) begin
        ctr  = middle_line[c];
        peak = 1'b1;
        if (row > 1) if (above_line[c] >= ctr) peak = 1'b0;
        if (b.pixel_value >= ctr) peak = 1'b0;
        if (c > 0) if (above_line[c-1] >= ctr) peak = 1'b0;
        if (c + 1 < w) if (middle_line[c+1] >= ctr) peak = 1'b0;
        v.peak_row     = lpd_pkg::ROW_BITS'(row - 1);
        v.peak_col     = lpd_pkg::COL_BITS'(c);
        v.center_value = ctr;
        v.is_peak      = peak;
        v.frame_last   = 1'b0;
        pending_verdicts.push_back(v);
        above_line[c] = ctr;
      end
      middle_line[c] = b.pixel_value;

      // Advance the raster position; the frame's last pixel opens the drain phase.
      if (c + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          row      = 0;
          draining = 1'b1;
          drained  = 0;
        end else begin
          row++;
        end
      end else begin
        col = c + 1;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one result beat with the oldest verdict still owed.
    task match_result(lpd_pkg::out_beat_t got);
      lpd_pkg::out_beat_t want;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                got.peak_row, got.peak_col, got.center_value));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.peak_row !== want.peak_row)
        flag_mismatch($sformatf("peak_row got %0d want %0d", got.peak_row, want.peak_row));
      if (got.peak_col !== want.peak_col)
        flag_mismatch($sformatf("peak_col got %0d want %0d", got.peak_col, want.peak_col));
      if (got.center_value !== want.center_value)
        flag_mismatch($sformatf("center_value got %0d want %0d at row %0d col %0d",
                                got.center_value, want.center_value,
                                want.peak_row, want.peak_col));
      if (got.is_peak !== want.is_peak)
        flag_mismatch($sformatf("is_peak got %0b want %0b at row %0d col %0d",
                                got.is_peak, want.is_peak, want.peak_row, want.peak_col));
      if (got.frame_last !== want.frame_last)
        flag_mismatch($sformatf("frame_last got %0b want %0b at row %0d col %0d",
                                got.frame_last, want.frame_last,
                                want.peak_row, want.peak_col));
    endtask

    task close_out();
      if (pending_verdicts.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived, oldest row %0d col %0d",
                                pending_verdicts.size(), pending_verdicts[0].peak_row,
                                pending_verdicts[0].peak_col));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  lpd_pkg::cfg_reg_t            cfg_index;
  logic [lpd_pkg::CFG_BITS-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  lpd_pkg::in_beat_t            in_data;
  logic                         out_valid;
  logic                         out_ready;
  lpd_pkg::out_beat_t           out_data;

  peak_judge  judge;
  bit         idle_on;
  bit         long_hold_req;
  int         regular_beats;

  local_peak_detect_4n uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 5);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) judge.match_result(out_data);
  end

  // Mostly small values to provoke ties, some extremes, the rest anywhere.
  function automatic logic signed [lpd_pkg::PIXEL_BITS-1:0] pick_pixel();
    logic signed [lpd_pkg::PIXEL_BITS-1:0] px;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: px = lpd_pkg::PIXEL_BITS'($urandom_range(0, 6) - 3);
      5: begin
        case ($urandom_range(0, 3))
          0:       px = 16'sh7FFF;
          1:       px = 16'sh8000;
          2:       px = '0;
          default: px = '1;
        endcase
      end
      default: px = lpd_pkg::PIXEL_BITS'($urandom);
    endcase
    return px;
  endfunction

  // Offer one beat, possibly after a short gap, and hold it until it is taken.
  task automatic send_beat(lpd_pkg::action_t act,
                           logic signed [lpd_pkg::PIXEL_BITS-1:0] px);
    int                gap;
    lpd_pkg::in_beat_t b;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    b.action      = act;
    b.pixel_value = px;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    judge.take_beat(b);
  endtask

  // Drop valid and let every owed result come out, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (judge.pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write both size registers on back-to-back cycles; only called while idle.
  task automatic write_frame_size(logic [lpd_pkg::CFG_BITS-1:0] w,
                                  logic [lpd_pkg::CFG_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= lpd_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= lpd_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    judge.set_size(lpd_pkg::REG_FRAME_WIDTH, w);
    judge.set_size(lpd_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // One whole frame and its drain, with stray beats that the block should drop.
  task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
    for (int unsigned p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(0, 11) == 0) send_beat(lpd_pkg::ACT_DRAIN, pick_pixel());
      send_beat(lpd_pkg::ACT_PIXEL, pick_pixel());
      regular_beats++;
    end
    for (int unsigned d = 0; d < w; d++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_beat(lpd_pkg::ACT_PIXEL, pick_pixel());
      send_beat(lpd_pkg::ACT_DRAIN, pick_pixel());
      regular_beats++;
    end
    if (noisy && $urandom_range(0, 5) == 0) send_beat(lpd_pkg::ACT_DRAIN, pick_pixel());
  endtask

  // Main sequence.
  initial begin
    int                           phase;
    logic [lpd_pkg::CFG_BITS-1:0] w_cfg;
    logic [lpd_pkg::CFG_BITS-1:0] h_cfg;
    judge         = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    regular_beats = 0;
    phase         = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = lpd_pkg::REG_FRAME_WIDTH;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frame at the reset size, with stray drain and pixel beats around it.
    send_beat(lpd_pkg::ACT_DRAIN, '0);
    for (int i = 0; i < 12; i++) send_beat(lpd_pkg::ACT_PIXEL, OPENING_FRAME[i]);
    send_beat(lpd_pkg::ACT_PIXEL, 16'sh1234);
    for (int i = 0; i < 4; i++) send_beat(lpd_pkg::ACT_DRAIN, '1);
    send_beat(lpd_pkg::ACT_DRAIN, '0);
    wait_idle();

    // Random phases: a new size, then a few frames with random content.
    regular_beats = 0;
    while (regular_beats < RANDOM_BEATS || phase < 4) begin
      phase++;
      case ($urandom_range(0, 9))
        0:       w_cfg = '0;
        1:       w_cfg = lpd_pkg::CFG_BITS'(1);
        default: w_cfg = lpd_pkg::CFG_BITS'($urandom_range(2, 10));
      endcase
      case ($urandom_range(0, 9))
        0:       h_cfg = '0;
        1:       h_cfg = lpd_pkg::CFG_BITS'(1);
        default: h_cfg = lpd_pkg::CFG_BITS'($urandom_range(2, 6));
      endcase
      // One phase fills the block while the result side holds off for a long time.
      if (phase == 4) begin
        w_cfg = lpd_pkg::CFG_BITS'(8);
        h_cfg = lpd_pkg::CFG_BITS'(5);
      end
      idle_on = ($urandom_range(0, 4) != 0);
      write_frame_size(w_cfg, h_cfg);
      if (phase == 4) long_hold_req = 1'b1;
      repeat ($urandom_range(1, 3))
        run_frame(judge.clamp_dim(w_cfg, lpd_pkg::MAX_WIDTH_DEF),
                  judge.clamp_dim(h_cfg, lpd_pkg::MAX_HEIGHT_DEF), 1'b1);
      wait_idle();
    end

    // Zero sizes act as one: a single-pixel frame.
    idle_on = 1'b1;
    write_frame_size('0, '0);
    run_frame(judge.clamp_dim('0, lpd_pkg::MAX_WIDTH_DEF),
              judge.clamp_dim('0, lpd_pkg::MAX_HEIGHT_DEF), 1'b1);
    wait_idle();

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    w_cfg = lpd_pkg::CFG_BITS'($urandom_range(2, 10));
    h_cfg = lpd_pkg::CFG_BITS'($urandom_range(2, 6));
    write_frame_size(w_cfg, h_cfg);
    repeat (2)
      run_frame(judge.clamp_dim(w_cfg, lpd_pkg::MAX_WIDTH_DEF),
                judge.clamp_dim(h_cfg, lpd_pkg::MAX_HEIGHT_DEF), 1'b1);
    wait_idle();

    judge.close_out();
    if (judge.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
